// ===== sv/assert_macros.svh =====
// Assertion macros shared by the timer RTL.
// Used by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/ptmr_pkg.sv =====
// Package for the periodic duty schedule timer: widths, constants, types.
// No dependencies.
package ptmr_pkg;
	localparam int DUR_W  = 12;
	localparam int PER_W  = 10;
	localparam int SPAN_W = 22;   // period in seconds, up to 1023 h
	localparam int DSEC_W = 18;   // duration in seconds, up to 4095 min
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 12;

	localparam logic [DSEC_W-1:0] SEC_PER_MIN = DSEC_W'(60);
	localparam logic [SPAN_W-1:0] SEC_PER_HR  = SPAN_W'(60 * 60);

	localparam logic [DUR_W-1:0] FAN_DUR_RST   = DUR_W'(15);
	localparam logic [PER_W-1:0] FAN_PER_RST   = PER_W'(1);
	localparam logic [DUR_W-1:0] WATER_DUR_RST = DUR_W'(5);
	localparam logic [PER_W-1:0] WATER_PER_RST = PER_W'(24);

	typedef enum logic [CFG_AW-1:0] {
		REG_FAN_DUR   = 3'd0,
		REG_FAN_PER   = 3'd1,
		REG_WATER_DUR = 3'd2,
		REG_WATER_PER = 3'd3,
		REG_AUTO      = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [DUR_W-1:0] fan_dur;
		logic [PER_W-1:0] fan_per;
		logic [DUR_W-1:0] water_dur;
		logic [PER_W-1:0] water_per;
		logic             auto_mode;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;
endpackage

// ===== sv/ptmr_cfg.sv =====
// Configuration register file for the schedule timer.
// Depends on ptmr_pkg.
module ptmr_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            we,
	input  logic [ptmr_pkg::CFG_AW-1:0]     addr,
	input  logic [ptmr_pkg::CFG_DW-1:0]     wdata,
	output ptmr_pkg::cfg_t                  cfg
);
	import ptmr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fan_dur   <= FAN_DUR_RST;
			cfg_q.fan_per   <= FAN_PER_RST;
			cfg_q.water_dur <= WATER_DUR_RST;
			cfg_q.water_per <= WATER_PER_RST;
			cfg_q.auto_mode <= 1'b1;
		end else if (we) begin
			case (addr)
				REG_FAN_DUR:   cfg_q.fan_dur   <= wdata[DUR_W-1:0];
				REG_FAN_PER:   cfg_q.fan_per   <= wdata[PER_W-1:0];
				REG_WATER_DUR: cfg_q.water_dur <= wdata[DUR_W-1:0];
				REG_WATER_PER: cfg_q.water_per <= wdata[PER_W-1:0];
				REG_AUTO:      cfg_q.auto_mode <= wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

// ===== sv/ptmr_remdiv.sv =====
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on ptmr_pkg.
module ptmr_remdiv #(
	parameter int DIVIDEND_BITS = 40
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [DIVIDEND_BITS-1:0]      dividend,
	input  logic [ptmr_pkg::SPAN_W-1:0]   divisor,
	output logic [ptmr_pkg::SPAN_W-1:0]   rem,
	output ptmr_pkg::div_stat_t           stat
);
	import ptmr_pkg::*;

	localparam int CNT_W = $clog2(DIVIDEND_BITS + 1);

	logic [DIVIDEND_BITS-1:0] dvd_q;
	logic [SPAN_W-1:0]        div_q;
	logic [SPAN_W-1:0]        rem_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic [SPAN_W:0]          trial;
	logic [SPAN_W:0]          diff;

	assign trial = {rem_q, dvd_q[DIVIDEND_BITS-1]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DIVIDEND_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			if (trial >= {1'b0, div_q})
				rem_q <= diff[SPAN_W-1:0];
			else
				rem_q <= trial[SPAN_W-1:0];
		end
	end

	assign rem       = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule

// ===== sv/periodic_duty_schedule_timer.sv =====
// Periodic duty schedule timer: each tick item carries the time in seconds and
// yields one result item with the fan and watering states, the next watering
// start and a save request. One item at a time: s_tready is high only while
// idle. Each item runs the single remainder unit, which retires one dividend bit
// per cycle, once for the fan and once for the watering channel. A finished
// result waits in the output register while the next item is taken.
`include "assert_macros.svh"
module periodic_duty_schedule_timer #(
	parameter int TIME_BITS = 40
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_we,
	input  logic [2:0]                                cfg_addr,
	input  logic [11:0]                               cfg_wdata,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// now_seconds
	input  logic [((TIME_BITS + 7) / 8) * 8 - 1:0]    s_tdata,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// fan_on, water_on, next_water_time, save_request
	output logic [((TIME_BITS + 10) / 8) * 8 - 1:0]   m_tdata
);
	import ptmr_pkg::*;

	localparam int OUT_W = ((TIME_BITS + 10) / 8) * 8;

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_FAN_ST  = 7'b0000010,
		S_FAN_RUN = 7'b0000100,
		S_WAT_ST  = 7'b0001000,
		S_WAT_RUN = 7'b0010000,
		S_NEXT    = 7'b0100000,
		S_EMIT    = 7'b1000000
	} state_t;

	state_t state_q;
	cfg_t   cfg;
	div_stat_t dstat;

	logic [TIME_BITS-1:0] now;
	logic [TIME_BITS-1:0] now_q;
	logic [TIME_BITS-1:0] fan_epoch_q, water_epoch_q;
	logic [DUR_W-1:0]     sv_fan_dur_q, sv_water_dur_q;
	logic [PER_W-1:0]     sv_fan_per_q, sv_water_per_q;
	logic                 changed_q;
	logic [SPAN_W-1:0]    fan_per_s_q, water_per_s_q;
	logic [DSEC_W-1:0]    fan_dur_s_q, water_dur_s_q;
	logic                 fan_lt_q, water_lt_q;
	logic [TIME_BITS-1:0] base_q;
	logic                 held_fan_q, held_water_q;
	logic [TIME_BITS-1:0] held_next_q;
	logic                 out_valid_q;
	logic                 out_fan_q, out_water_q, out_save_q;
	logic [TIME_BITS-1:0] out_next_q;

	logic                 accept;
	logic                 fan_chg, water_chg;
	logic [TIME_BITS:0]   fan_diff, water_diff;
	logic                 div_start;
	logic [TIME_BITS-1:0] div_dvd;
	logic [SPAN_W-1:0]    div_dvs;
	logic [SPAN_W-1:0]    rem;
	logic                 fan_en, water_en;
	logic                 fan_on_c, water_on_c;
	logic [TIME_BITS:0]   next_sum;
	logic                 out_load;

	ptmr_cfg u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (cfg_we),
		.addr  (cfg_addr),
		.wdata (cfg_wdata),
		.cfg   (cfg)
	);

	ptmr_remdiv #(.DIVIDEND_BITS(TIME_BITS)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dvd),
		.divisor (div_dvs),
		.rem     (rem),
		.stat    (dstat)
	);

	assign now       = s_tdata[TIME_BITS-1:0];
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign fan_chg   = (cfg.fan_dur != sv_fan_dur_q) || (cfg.fan_per != sv_fan_per_q);
	assign water_chg = (cfg.water_dur != sv_water_dur_q) || (cfg.water_per != sv_water_per_q);

	assign fan_diff   = {1'b0, now_q} - {1'b0, fan_epoch_q};
	assign water_diff = {1'b0, now_q} - {1'b0, water_epoch_q};
	assign div_start  = (state_q == S_FAN_ST) || (state_q == S_WAT_ST);
	assign div_dvd    = (state_q == S_WAT_ST) ? water_diff[TIME_BITS-1:0]
	                                          : fan_diff[TIME_BITS-1:0];
	assign div_dvs    = (state_q == S_WAT_ST) ? water_per_s_q : fan_per_s_q;

	assign fan_en   = (fan_epoch_q != '0) && (fan_per_s_q != '0) && (fan_dur_s_q != '0);
	assign water_en = (water_epoch_q != '0) && (water_per_s_q != '0) &&
	                  (water_dur_s_q != '0);
	assign fan_on_c = fan_en && !fan_lt_q &&
	                  ((SPAN_W'(fan_dur_s_q) >= fan_per_s_q) || (rem < SPAN_W'(fan_dur_s_q)));
	assign water_on_c = water_en && !water_lt_q &&
	                  ((SPAN_W'(water_dur_s_q) >= water_per_s_q) ||
	                   (rem < SPAN_W'(water_dur_s_q)));
	assign next_sum = {1'b0, base_q} + (TIME_BITS + 1)'(water_per_s_q);
	assign out_load = (state_q == S_EMIT) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			fan_epoch_q    <= '0;
			water_epoch_q  <= '0;
			sv_fan_dur_q   <= FAN_DUR_RST;
			sv_fan_per_q   <= FAN_PER_RST;
			sv_water_dur_q <= WATER_DUR_RST;
			sv_water_per_q <= WATER_PER_RST;
			held_fan_q     <= 1'b0;
			held_water_q   <= 1'b0;
			held_next_q    <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (fan_chg || (fan_epoch_q == '0))
							fan_epoch_q <= now;
						if (water_chg || (water_epoch_q == '0))
							water_epoch_q <= now;
						sv_fan_dur_q   <= cfg.fan_dur;
						sv_fan_per_q   <= cfg.fan_per;
						sv_water_dur_q <= cfg.water_dur;
						sv_water_per_q <= cfg.water_per;
						state_q        <= S_FAN_ST;
					end
				end
				S_FAN_ST:  state_q <= S_FAN_RUN;
				S_FAN_RUN: begin
					if (dstat.done) begin
						if (cfg.auto_mode)
							held_fan_q <= fan_on_c;
						state_q <= S_WAT_ST;
					end
				end
				S_WAT_ST:  state_q <= S_WAT_RUN;
				S_WAT_RUN: begin
					if (dstat.done) begin
						if (cfg.auto_mode)
							held_water_q <= water_on_c;
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (cfg.auto_mode) begin
						if (!water_en)
							held_next_q <= '0;
						else if (water_lt_q)
							held_next_q <= water_epoch_q;
						else if (next_sum[TIME_BITS])
							held_next_q <= '1;
						else
							held_next_q <= next_sum[TIME_BITS-1:0];
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			now_q         <= now;
			changed_q     <= fan_chg || water_chg || (fan_epoch_q == '0) ||
			                 (water_epoch_q == '0);
			fan_per_s_q   <= SPAN_W'(cfg.fan_per) * SEC_PER_HR;
			water_per_s_q <= SPAN_W'(cfg.water_per) * SEC_PER_HR;
			fan_dur_s_q   <= DSEC_W'(cfg.fan_dur) * SEC_PER_MIN;
			water_dur_s_q <= DSEC_W'(cfg.water_dur) * SEC_PER_MIN;
		end
		if (state_q == S_FAN_ST)
			fan_lt_q <= fan_diff[TIME_BITS];
		if (state_q == S_WAT_ST)
			water_lt_q <= water_diff[TIME_BITS];
		if ((state_q == S_WAT_RUN) && dstat.done)
			base_q <= now_q - TIME_BITS'(rem);
		if (out_load) begin
			out_fan_q   <= held_fan_q;
			out_water_q <= held_water_q;
			out_next_q  <= held_next_q;
			out_save_q  <= changed_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({out_save_q, out_next_q, out_water_q, out_fan_q});

	`ASSERT_IMPL(a_ready_not_busy, clk, arst_n, s_tready, !dstat.busy)
	`ASSERT_NEXT(a_accept_blocks, clk, arst_n, accept, !s_tready)
	`ASSERT_IMPL(a_done_in_run, clk, arst_n, dstat.done,
		(state_q == S_FAN_RUN) || (state_q == S_WAT_RUN))
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for periodic_duty_schedule_timer: time-tick items in,
// predicted fan/watering state, next watering start and save request checked.
// Depends on ptmr_pkg and the timer RTL only.
module tb;
	import ptmr_pkg::*;

	localparam int TIME_W = 40;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

	typedef struct packed {
		logic              fan_on;
		logic              water_on;
		logic [TIME_W-1:0] next_water;
		logic              save_req;
	} tick_result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_addr = '0;
	logic [11:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // now_seconds
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;        // fan_on, water_on, next_water_time, save_request

	// schedule model
	cfg_t              sched;
	logic [DUR_W-1:0]  saved_fan_dur, saved_water_dur;
	logic [PER_W-1:0]  saved_fan_per, saved_water_per;
	logic [TIME_W-1:0] fan_epoch, water_epoch, held_next_water;
	logic              held_fan_on, held_water_on;

	logic [TIME_W-1:0] tick_q[$];
	tick_result_t      expected_q[$];
	tick_result_t      got_r, want_r;
	logic [TIME_W-1:0] clock_now;

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_len = 0;
	int stall_left = 0;
	int errors = 0;
	int ticks_sent = 0;
	int results_checked = 0;
	int reg_writes = 0;
	int fan_on_seen = 0;
	int water_on_seen = 0;
	int saves_seen = 0;
	int saturated_seen = 0;

	periodic_duty_schedule_timer #(.TIME_BITS(TIME_W)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	function automatic logic duty_active(input logic [DUR_W-1:0] dur,
		input logic [PER_W-1:0] per, input logic [TIME_W-1:0] anchor,
		input logic [TIME_W-1:0] now_s);
		logic [63:0] span, on_len;
		if (anchor == '0 || now_s < anchor || per == '0 || dur == '0)
			return 1'b0;
		span = 64'(per) * 64'(SEC_PER_HR);
		on_len = 64'(dur) * 64'(SEC_PER_MIN);
		if (on_len >= span)
			return 1'b1;
		return (64'(now_s - anchor) % span) < on_len;
	endfunction

	function automatic logic [TIME_W-1:0] next_watering(input logic [DUR_W-1:0] dur,
		input logic [PER_W-1:0] per, input logic [TIME_W-1:0] anchor,
		input logic [TIME_W-1:0] now_s);
		logic [63:0] span, base;
		if (anchor == '0 || per == '0 || dur == '0)
			return '0;
		if (now_s < anchor)
			return anchor;
		span = 64'(per) * 64'(SEC_PER_HR);
		base = 64'(now_s) - (64'(now_s - anchor) % span);
		if (base > 64'(TIME_MAX) - span)
			return TIME_MAX;
		return TIME_W'(base + span);
	endfunction

	function automatic tick_result_t advance_schedule(input logic [TIME_W-1:0] now_s);
		logic changed;
		tick_result_t r;
		changed = 1'b0;
		if (fan_epoch == '0) begin
			fan_epoch = now_s;
			changed = 1'b1;
		end
		if (water_epoch == '0) begin
			water_epoch = now_s;
			changed = 1'b1;
		end
		if (sched.fan_dur != saved_fan_dur || sched.fan_per != saved_fan_per) begin
			saved_fan_dur = sched.fan_dur;
			saved_fan_per = sched.fan_per;
			fan_epoch = now_s;
			changed = 1'b1;
		end
		if (sched.water_dur != saved_water_dur || sched.water_per != saved_water_per) begin
			saved_water_dur = sched.water_dur;
			saved_water_per = sched.water_per;
			water_epoch = now_s;
			changed = 1'b1;
		end
		if (sched.auto_mode) begin
			held_fan_on = duty_active(sched.fan_dur, sched.fan_per, fan_epoch, now_s);
			held_water_on = duty_active(sched.water_dur, sched.water_per, water_epoch, now_s);
			held_next_water = next_watering(sched.water_dur, sched.water_per,
				water_epoch, now_s);
		end
		r.fan_on = held_fan_on;
		r.water_on = held_water_on;
		r.next_water = held_next_water;
		r.save_req = changed;
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// tick driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_q.push_back(advance_schedule(s_tdata[TIME_W-1:0]));
				ticks_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (tick_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= tick_q.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_r.fan_on = m_tdata[0];
				got_r.water_on = m_tdata[1];
				got_r.next_water = m_tdata[TIME_W+1:2];
				got_r.save_req = m_tdata[TIME_W+2];
				if (expected_q.size() == 0) begin
					errors++;
					$display("%0t: result item with none expected: %h", $time, m_tdata);
				end else begin
					want_r = expected_q.pop_front();
					results_checked++;
					if (got_r.fan_on !== want_r.fan_on) begin
						errors++;
						$display("%0t: fan_on expected %0d got %0d", $time,
							want_r.fan_on, got_r.fan_on);
					end
					if (got_r.water_on !== want_r.water_on) begin
						errors++;
						$display("%0t: water_on expected %0d got %0d", $time,
							want_r.water_on, got_r.water_on);
					end
					if (got_r.next_water !== want_r.next_water) begin
						errors++;
						$display("%0t: next_water_time expected %0d got %0d", $time,
							want_r.next_water, got_r.next_water);
					end
					if (got_r.save_req !== want_r.save_req) begin
						errors++;
						$display("%0t: save_request expected %0d got %0d", $time,
							want_r.save_req, got_r.save_req);
					end
					fan_on_seen += want_r.fan_on;
					water_on_seen += want_r.water_on;
					saves_seen += want_r.save_req;
					saturated_seen += (want_r.next_water == TIME_MAX);
				end
			end
			if (hold_req != hold_ack) begin
				hold_ack <= hold_req;
				stall_left <= hold_len;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_FAN_DUR:   sched.fan_dur = val[DUR_W-1:0];
			REG_FAN_PER:   sched.fan_per = val[PER_W-1:0];
			REG_WATER_DUR: sched.water_dur = val[DUR_W-1:0];
			REG_WATER_PER: sched.water_per = val[PER_W-1:0];
			REG_AUTO:      sched.auto_mode = val[0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic end_writes;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_idling(input int tx, input int rx);
		@(posedge clk);
		tx_idle_pct <= tx;
		rx_stall_pct <= rx;
	endtask

	task automatic wait_drained;
		while (tick_q.size() != 0 || s_tvalid || expected_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [TIME_W-1:0] rand_time;
		return TIME_W'({$urandom(), $urandom()});
	endfunction

	function automatic logic [11:0] pick_minutes;
		int r;
		r = $urandom_range(99);
		if (r < 8) return '0;
		if (r < 14) return 12'd4095;
		if (r < 70) return 12'($urandom_range(1, 120));
		return 12'($urandom_range(0, 4095));
	endfunction

	// full 12-bit data now and then; the period register keeps the low 10 bits
	function automatic logic [11:0] pick_hours;
		int r;
		r = $urandom_range(99);
		if (r < 8) return '0;
		if (r < 14) return 12'd1023;
		if (r < 75) return 12'($urandom_range(1, 4));
		return 12'($urandom_range(0, 4095));
	endfunction

	task automatic random_schedule;
		if ($urandom_range(99) < 70) write_reg(REG_FAN_DUR, pick_minutes());
		if ($urandom_range(99) < 70) write_reg(REG_FAN_PER, pick_hours());
		if ($urandom_range(99) < 70) write_reg(REG_WATER_DUR, pick_minutes());
		if ($urandom_range(99) < 70) write_reg(REG_WATER_PER, pick_hours());
		if ($urandom_range(99) < 50)
			write_reg(REG_AUTO, 12'($urandom_range(99) < 85));
		if ($urandom_range(99) < 10)
			write_reg(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
				12'($urandom_range(0, 4095)));
		end_writes();
	endtask

	// mostly a running clock with small steps, some jumps, some noise
	task automatic queue_ticks(input int n);
		int r;
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 60)
				clock_now = clock_now + TIME_W'($urandom_range(1, 5));
			else if (r < 75)
				clock_now = clock_now + TIME_W'($urandom_range(60, 3600));
			else if (r < 85)
				clock_now = clock_now + TIME_W'($urandom_range(3600, 200000));
			else if (r < 90)
				clock_now = clock_now - TIME_W'($urandom_range(1, 7200));
			else if (r < 95)
				clock_now = rand_time();
			else if (r < 98)
				clock_now = TIME_MAX - TIME_W'($urandom_range(0, 4000000));
			if (r >= 98)
				tick_q.push_back('0);
			else
				tick_q.push_back(clock_now);
		end
	endtask

	initial begin
		sched.fan_dur = FAN_DUR_RST;
		sched.fan_per = FAN_PER_RST;
		sched.water_dur = WATER_DUR_RST;
		sched.water_per = WATER_PER_RST;
		sched.auto_mode = 1'b1;
		saved_fan_dur = FAN_DUR_RST;
		saved_fan_per = FAN_PER_RST;
		saved_water_dur = WATER_DUR_RST;
		saved_water_per = WATER_PER_RST;
		fan_epoch = '0;
		water_epoch = '0;
		held_fan_on = 1'b0;
		held_water_on = 1'b0;
		held_next_water = '0;
		clock_now = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset schedule: zero time, first anchor, on/off edges, saturation, before anchor
		tick_q = '{40'd0, 40'd0, 40'd7, 40'd400, 40'd1000, 40'd3610, TIME_MAX, 40'd3};
		wait_drained();
		// duration beyond period, watering disabled by zero duration
		write_reg(REG_FAN_DUR, 12'd4095);
		write_reg(REG_FAN_PER, 12'd1);
		write_reg(REG_WATER_DUR, 12'd0);
		end_writes();
		tick_q = '{40'd50000, 40'd50001};
		wait_drained();
		// largest period, duration boundary
		write_reg(REG_FAN_PER, 12'hFFF);
		write_reg(REG_WATER_DUR, 12'd4095);
		write_reg(REG_WATER_PER, 12'd1023);
		end_writes();
		tick_q = '{40'd60000, 40'd305700, 40'd305699};
		wait_drained();
		write_reg(REG_WATER_PER, 12'd0);
		end_writes();
		tick_q = '{40'd400000};
		wait_drained();
		// manual mode holds outputs but still reports changes
		write_reg(REG_AUTO, 12'd0);
		write_reg(REG_WATER_PER, 12'd2);
		end_writes();
		tick_q = '{40'd500000, TIME_MAX};
		wait_drained();
		write_reg(REG_SPARE_FIRST, 12'hFFF);
		write_reg(REG_SPARE_LAST, 12'h000);
		end_writes();
		tick_q = '{40'd600000};
		wait_drained();
		write_reg(REG_AUTO, 12'd1);
		write_reg(REG_FAN_DUR, 12'd0);
		end_writes();
		tick_q = '{40'd700000, 40'd701000};
		wait_drained();
		// anchor reloaded at time zero stays zero
		write_reg(REG_WATER_DUR, 12'd7);
		end_writes();
		tick_q = '{40'd0, 40'd1, 40'd2};
		wait_drained();

		// long output hold-off while the sender keeps offering
		set_idling(0, 0);
		write_reg(REG_FAN_DUR, 12'd20);
		write_reg(REG_FAN_PER, 12'd1);
		end_writes();
		clock_now = 40'd1000;
		queue_ticks(40);
		hold_len <= 1000;
		hold_req <= hold_req + 1;
		wait_drained();

		for (int p = 0; p < 12; p++) begin
			case (p % 4)
				0: set_idling(0, 0);
				1: set_idling(50, 0);
				2: set_idling(0, 50);
				default: set_idling(17, 17);
			endcase
			random_schedule();
			if ($urandom_range(99) < 40)
				clock_now = rand_time();
			queue_ticks(135);
			wait_drained();
		end

		repeat (200) @(posedge clk);
		if (expected_q.size() != 0) begin
			errors++;
			$display("%0t: %0d result items never arrived", $time, expected_q.size());
		end
		$display("%0d ticks checked over %0d register writes: fan on %0d, water on %0d",
			results_checked, reg_writes, fan_on_seen, water_on_seen);
		$display("save requests %0d, saturated next start %0d", saves_seen, saturated_seen);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#(15_000_000);
		$display("simulation failed");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+sv
sv/ptmr_pkg.sv
sv/ptmr_cfg.sv
sv/ptmr_remdiv.sv
sv/periodic_duty_schedule_timer.sv
tb/tb.sv
